// ----- hw/rtl/cfcr_pkg.sv -----
// Shared types, constants and the byte-wise CRC-16/Modbus update for the frame checker.
package cfcr_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] REPLY_LEAD   = 8'hFF;
    localparam logic [7:0] CODE_UNKNOWN = 8'h01;
    localparam logic [7:0] CODE_BAD_CRC = 8'h02;
    localparam logic [7:0] CODE_ACK     = 8'h03;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W   = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD0    = 3'd2;

    localparam logic [7:0] RESET_HEADER  = 8'hFF;
    localparam logic [7:0] RESET_STATION = 8'h00;
    localparam int unsigned NUM_CMD      = 6;
    localparam int unsigned CMD_IW       = 3;
    localparam int unsigned CMD_RESET_BASE = 1;

    // frame position counter
    localparam int unsigned POS_W = 9;
    localparam logic [POS_W-1:0] POS_HEADER  = 9'd0;
    localparam logic [POS_W-1:0] POS_STATION = 9'd1;
    localparam logic [POS_W-1:0] POS_CMD     = 9'd2;
    localparam logic [POS_W-1:0] POS_LEN     = 9'd3;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd4;
    localparam logic [7:0]       MIN_LEN     = 8'd2;

    // reply byte slots
    localparam int unsigned RIDX_W = 3;
    localparam logic [RIDX_W-1:0] RB_LEAD   = 3'd0;
    localparam logic [RIDX_W-1:0] RB_SID    = 3'd1;
    localparam logic [RIDX_W-1:0] RB_CODE   = 3'd2;
    localparam logic [RIDX_W-1:0] RB_CRC_LO = 3'd3;
    localparam logic [RIDX_W-1:0] RB_CRC_HI = 3'd4;

    // reply queue
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = 1;
    localparam int unsigned Q_CW    = 2;

    typedef struct packed {
        logic [7:0] sid;
        logic [7:0] code;
    } t_reply;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/cfcr_front.sv -----
// Front end: config registers, frame parser, running CRC and reply classification.
module cfcr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfcr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_rx_valid,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_rx_stall,
    input  logic                           i_q_full,
    output logic                           o_push,
    output cfcr_pkg::t_reply               o_reply
);

    logic [7:0]  r_header;
    logic [7:0]  r_station;
    logic [7:0]  r_cmd [cfcr_pkg::NUM_CMD];

    logic [cfcr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cmd_val, n_cmd_val;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic        r_here, n_here;

    logic                       w_acc;
    logic [cfcr_pkg::POS_W-1:0] w_len_end;
    logic [15:0]                w_crc_upd;
    logic                       w_known;
    logic [7:0]                 w_code;
    logic [cfcr_pkg::CMD_IW-1:0] w_cmd_sel;

    assign o_rx_stall = i_q_full;
    assign w_acc      = i_rx_valid && !i_q_full;
    assign w_len_end  = {1'b0, r_len} + cfcr_pkg::POS_W'(2);
    assign w_crc_upd  = cfcr_pkg::crc_feed(
        (r_pos == cfcr_pkg::POS_HEADER) ? cfcr_pkg::CRC_INIT : r_crc, i_rx_byte);
    assign w_cmd_sel  = cfcr_pkg::CMD_IW'(i_cfg_idx - cfcr_pkg::CFG_CMD0);

    always_comb begin
        w_known = 1'b0;
        for (int i = 0; i < cfcr_pkg::NUM_CMD; i++) begin
            if (r_cmd_val == r_cmd[i]) w_known = 1'b1;
        end
    end

    // incoming CRC high byte completes the received word
    always_comb begin
        if ({i_rx_byte, r_crc_lo} != r_crc) begin
            w_code = cfcr_pkg::CODE_BAD_CRC;
        end else if (w_known) begin
            w_code = cfcr_pkg::CODE_ACK;
        end else begin
            w_code = cfcr_pkg::CODE_UNKNOWN;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_len     = r_len;
        n_cmd_val = r_cmd_val;
        n_crc_lo  = r_crc_lo;
        n_here    = r_here;
        o_push    = 1'b0;
        if (w_acc) begin
            priority if (r_pos == cfcr_pkg::POS_HEADER) begin
                if (i_rx_byte == r_header) begin
                    n_crc = w_crc_upd;
                    n_pos = cfcr_pkg::POS_STATION;
                end
            end else if (r_pos == cfcr_pkg::POS_STATION) begin
                n_here = (i_rx_byte == r_station);
                n_crc  = w_crc_upd;
                n_pos  = cfcr_pkg::POS_CMD;
            end else if (r_pos == cfcr_pkg::POS_CMD) begin
                n_cmd_val = i_rx_byte;
                n_crc     = w_crc_upd;
                n_pos     = cfcr_pkg::POS_LEN;
            end else if (r_pos == cfcr_pkg::POS_LEN) begin
                n_len = i_rx_byte;
                if (i_rx_byte < cfcr_pkg::MIN_LEN) begin
                    n_crc = cfcr_pkg::CRC_INIT;
                    n_pos = cfcr_pkg::POS_HEADER;
                end else begin
                    n_crc = w_crc_upd;
                    n_pos = cfcr_pkg::POS_PAYLOAD;
                end
            end else if (r_pos < w_len_end) begin
                n_crc = w_crc_upd;
                n_pos = r_pos + cfcr_pkg::POS_W'(1);
            end else if (r_pos == w_len_end) begin
                n_crc_lo = i_rx_byte;
                n_pos    = r_pos + cfcr_pkg::POS_W'(1);
            end else begin
                n_crc  = cfcr_pkg::CRC_INIT;
                n_pos  = cfcr_pkg::POS_HEADER;
                o_push = r_here;
            end
        end
    end

    assign o_reply.sid  = r_station;
    assign o_reply.code = w_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= cfcr_pkg::RESET_HEADER;
            r_station <= cfcr_pkg::RESET_STATION;
            for (int i = 0; i < cfcr_pkg::NUM_CMD; i++) begin
                r_cmd[i] <= 8'(i + cfcr_pkg::CMD_RESET_BASE);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfcr_pkg::CFG_HEADER:  r_header  <= i_cfg_data;
                cfcr_pkg::CFG_STATION: r_station <= i_cfg_data;
                default:               r_cmd[w_cmd_sel] <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= cfcr_pkg::POS_HEADER;
            r_crc     <= cfcr_pkg::CRC_INIT;
            r_len     <= '0;
            r_cmd_val <= '0;
            r_crc_lo  <= '0;
            r_here    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_len     <= n_len;
            r_cmd_val <= n_cmd_val;
            r_crc_lo  <= n_crc_lo;
            r_here    <= n_here;
        end
    end

endmodule

// ----- hw/rtl/cfcr_fifo.sv -----
// Two-entry queue of pending replies between the parser and the reply sender.
module cfcr_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cfcr_pkg::t_reply  i_data,
    input  logic              i_pop,
    output cfcr_pkg::t_reply  o_data,
    output cfcr_pkg::t_q_stat o_stat
);

    cfcr_pkg::t_reply r_mem [cfcr_pkg::Q_DEPTH];
    logic [cfcr_pkg::Q_AW-1:0] r_wp, n_wp;
    logic [cfcr_pkg::Q_AW-1:0] r_rp, n_rp;
    logic [cfcr_pkg::Q_CW-1:0] r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == cfcr_pkg::Q_CW'(cfcr_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) n_wp = r_wp + cfcr_pkg::Q_AW'(1);
        if (i_pop)  n_rp = r_rp + cfcr_pkg::Q_AW'(1);
        if (i_push && !i_pop) n_cnt = r_cnt + cfcr_pkg::Q_CW'(1);
        if (i_pop && !i_push) n_cnt = r_cnt - cfcr_pkg::Q_CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/cfcr_back.sv -----
// Back end: serializes one queued reply into five words, building the reply CRC as it sends.
module cfcr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  cfcr_pkg::t_reply  i_q_data,
    output logic              o_pop,
    output logic              o_tx_valid,
    input  logic              i_tx_stall,
    output logic [7:0]        o_tx_byte,
    output logic              o_is_last
);

    logic                         r_busy, n_busy;
    logic [cfcr_pkg::RIDX_W-1:0]  r_idx, n_idx;
    logic [15:0]                  r_crc, n_crc;
    cfcr_pkg::t_reply             r_rep, n_rep;

    logic w_acc;
    logic w_done;

    assign w_acc      = r_busy && !i_tx_stall;
    assign w_done     = w_acc && (r_idx == cfcr_pkg::RB_CRC_HI);
    assign o_pop      = (!r_busy || w_done) && !i_q_empty;
    assign o_tx_valid = r_busy;
    assign o_is_last  = (r_idx == cfcr_pkg::RB_CRC_HI);

    always_comb begin
        unique case (r_idx)
            cfcr_pkg::RB_LEAD:   o_tx_byte = cfcr_pkg::REPLY_LEAD;
            cfcr_pkg::RB_SID:    o_tx_byte = r_rep.sid;
            cfcr_pkg::RB_CODE:   o_tx_byte = r_rep.code;
            cfcr_pkg::RB_CRC_LO: o_tx_byte = r_crc[7:0];
            cfcr_pkg::RB_CRC_HI: o_tx_byte = r_crc[15:8];
            default:             o_tx_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_crc  = r_crc;
        n_rep  = r_rep;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = cfcr_pkg::RB_LEAD;
            n_crc  = cfcr_pkg::CRC_INIT;
            n_rep  = i_q_data;
        end else if (w_done) begin
            n_busy = 1'b0;
        end else if (w_acc) begin
            n_idx = r_idx + cfcr_pkg::RIDX_W'(1);
            // CRC covers the three header words only
            if (r_idx < cfcr_pkg::RB_CRC_LO) n_crc = cfcr_pkg::crc_feed(r_crc, o_tx_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= cfcr_pkg::RB_LEAD;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        r_rep <= n_rep;
    end

endmodule

// ----- hw/rtl/crc16_frame_checker_responder.sv -----
// Top level: framed command receiver with CRC-16/Modbus check and five-word status reply.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+------------------------
//   rx       | in        | i_rx_valid / o_rx_stall | i_rx_byte
//   tx       | out       | o_tx_valid / i_tx_stall | o_tx_byte, o_is_last
//   cfg      | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One rx word per cycle unless rx stalls; the byte-wise CRC update sets that figure.
// A reply leaves as five words, from the sender's word counter.
// Up to two replies wait in the queue; rx stalls only while that queue is full.
// Synchronous active-low reset restores the register defaults and hunts for a header.
module crc16_frame_checker_responder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfcr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_rx_valid,
    output logic                           o_rx_stall,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_tx_valid,
    input  logic                           i_tx_stall,
    output logic [7:0]                     o_tx_byte,
    output logic                           o_is_last
);

    cfcr_pkg::t_q_stat w_q_stat;
    cfcr_pkg::t_reply  w_push_data;
    cfcr_pkg::t_reply  w_pop_data;
    logic              w_push;
    logic              w_pop;

    cfcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_stall (o_rx_stall),
        .i_q_full   (w_q_stat.full),
        .o_push     (w_push),
        .o_reply    (w_push_data)
    );

    cfcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_stat  (w_q_stat)
    );

    cfcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_stat.empty),
        .i_q_data   (w_pop_data),
        .o_pop      (w_pop),
        .o_tx_valid (o_tx_valid),
        .i_tx_stall (i_tx_stall),
        .o_tx_byte  (o_tx_byte),
        .o_is_last  (o_is_last)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("reply pushed into full queue");

    a_q_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue both full and empty");

    a_reply_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_tx_valid) |-> (o_tx_byte == cfcr_pkg::REPLY_LEAD))
        else $error("reply does not start with lead word");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx_valid && !i_tx_stall && o_is_last && w_q_stat.empty) |=> !o_tx_valid)
        else $error("tx valid after last word with nothing queued");

endmodule

// ----- dv/tb_crc16_frame_checker_responder.sv -----
// Self-checking testbench for crc16_frame_checker_responder: random framed traffic, reply prediction.
`timescale 1ns / 100ps

module tb_crc16_frame_checker_responder;

    localparam int LONG_HOLD  = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply_word;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [cfcr_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [7:0]                     i_cfg_data = 8'h00;
    logic                           i_rx_valid = 1'b0;
    logic                           o_rx_stall;
    logic [7:0]                     i_rx_byte = 8'h00;
    logic                           o_tx_valid;
    logic                           i_tx_stall = 1'b0;
    logic [7:0]                     o_tx_byte;
    logic                           o_is_last;

    crc16_frame_checker_responder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_rx_byte  (i_rx_byte),
        .o_tx_valid (o_tx_valid),
        .i_tx_stall (i_tx_stall),
        .o_tx_byte  (o_tx_byte),
        .o_is_last  (o_is_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copy and frame parser state used for prediction
    logic [7:0]                 reg_shadow [8];
    logic [7:0]                 next_regs [8];
    logic [15:0]                acc_crc;
    logic [cfcr_pkg::POS_W-1:0] frame_pos;
    logic [7:0]                 frame_len;
    logic [7:0]                 frame_cmd;
    logic [7:0]                 rx_crc_lo;
    logic                       for_us;

    logic [7:0]  rx_pending [$];
    t_reply_word reply_words_due [$];

    int  err_count = 0;
    int  words_queued = 0;
    int  rx_taken = 0;
    int  tx_checked = 0;
    int  replies_seen = 0;
    int  settings_used = 1;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    bit  send_gaps_on = 1'b1;
    bit  recv_gaps_on = 1'b1;
    t_reply_word want;

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] seed,
                                                      input logic [7:0] d);
        logic [15:0] r;
        r = seed ^ {8'h00, d};
        repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ cfcr_pkg::CRC_POLY) : {1'b0, r[15:1]};
        return r;
    endfunction

    function automatic void restart_hunt();
        acc_crc   = cfcr_pkg::CRC_INIT;
        frame_pos = cfcr_pkg::POS_HEADER;
    endfunction

    // advance the parser by one rx word; queue the reply words it causes
    function automatic void parse_rx_byte(input logic [7:0] b);
        logic [15:0] got;
        logic [15:0] c;
        logic [7:0]  code;
        logic [7:0]  rep [5];
        t_reply_word w;
        if (frame_pos == cfcr_pkg::POS_HEADER) begin
            if (b == reg_shadow[cfcr_pkg::CFG_HEADER]) begin
                acc_crc   = crc16_modbus_byte(cfcr_pkg::CRC_INIT, b);
                frame_pos = cfcr_pkg::POS_STATION;
            end
        end else if (frame_pos == cfcr_pkg::POS_STATION) begin
            for_us    = (b == reg_shadow[cfcr_pkg::CFG_STATION]);
            acc_crc   = crc16_modbus_byte(acc_crc, b);
            frame_pos = cfcr_pkg::POS_CMD;
        end else if (frame_pos == cfcr_pkg::POS_CMD) begin
            frame_cmd = b;
            acc_crc   = crc16_modbus_byte(acc_crc, b);
            frame_pos = cfcr_pkg::POS_LEN;
        end else if (frame_pos == cfcr_pkg::POS_LEN) begin
            frame_len = b;
            if (b < cfcr_pkg::MIN_LEN) begin
                restart_hunt();
            end else begin
                acc_crc   = crc16_modbus_byte(acc_crc, b);
                frame_pos = cfcr_pkg::POS_PAYLOAD;
            end
        end else if (int'(frame_pos) < int'(frame_len) + 2) begin
            acc_crc   = crc16_modbus_byte(acc_crc, b);
            frame_pos = frame_pos + cfcr_pkg::POS_W'(1);
        end else if (int'(frame_pos) == int'(frame_len) + 2) begin
            rx_crc_lo = b;
            frame_pos = frame_pos + cfcr_pkg::POS_W'(1);
        end else begin
            got = {b, rx_crc_lo};
            if (got != acc_crc) begin
                code = cfcr_pkg::CODE_BAD_CRC;
            end else begin
                code = cfcr_pkg::CODE_UNKNOWN;
                for (int k = 0; k < cfcr_pkg::NUM_CMD; k++) begin
                    if (frame_cmd == reg_shadow[cfcr_pkg::CFG_CMD0 + k]) code = cfcr_pkg::CODE_ACK;
                end
            end
            restart_hunt();
            if (for_us) begin
                rep[0] = cfcr_pkg::REPLY_LEAD;
                rep[1] = reg_shadow[cfcr_pkg::CFG_STATION];
                rep[2] = code;
                c = cfcr_pkg::CRC_INIT;
                for (int k = 0; k < 3; k++) c = crc16_modbus_byte(c, rep[k]);
                rep[3] = c[7:0];
                rep[4] = c[15:8];
                for (int k = 0; k < 5; k++) begin
                    w.data = rep[k];
                    w.last = (k == 4);
                    reply_words_due.push_back(w);
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("%0t ns MISMATCH: %s", $time, what);
    endtask

    // rx driver: one word per handshake, random gap after each word unless send gaps are off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_rx_valid && !o_rx_stall) begin
                parse_rx_byte(i_rx_byte);
                rx_taken++;
            end
            if (!i_rx_valid || !o_rx_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_rx_valid <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    i_rx_byte  <= rx_pending.pop_front();
                    i_rx_valid <= 1'b1;
                    gap_left = send_gaps_on ? $urandom_range(0, 9) : 0;
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // tx stall: random per word unless receive gaps are off, plus a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_tx_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen  = hold_req;
                stall_left = LONG_HOLD;
            end else if (o_tx_valid && !i_tx_stall) begin
                stall_left = recv_gaps_on ? $urandom_range(0, 9) : 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_tx_stall <= 1'b1;
            end else begin
                i_tx_stall <= 1'b0;
            end
        end
    end

    // tx monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_tx_valid && !i_tx_stall) begin
            if (reply_words_due.size() == 0) begin
                report_mismatch($sformatf("reply word %02h with nothing expected", o_tx_byte));
            end else begin
                want = reply_words_due.pop_front();
                if (o_tx_byte !== want.data)
                    report_mismatch($sformatf("word %0d: tx_byte %02h, want %02h",
                                              tx_checked, o_tx_byte, want.data));
                if (o_is_last !== want.last)
                    report_mismatch($sformatf("word %0d: is_last %b, want %b",
                                              tx_checked, o_is_last, want.last));
                if (want.last) replies_seen++;
            end
            tx_checked++;
        end
    end

    task automatic push_word(input logic [7:0] b);
        rx_pending.push_back(b);
        words_queued++;
    endtask

    // one frame; len below 2 stops after the length word, drop_tail cuts words off the end
    task automatic queue_frame(input logic [7:0] hdr, input logic [7:0] sid,
                               input logic [7:0] cmd, input logic [7:0] len,
                               input bit crc_bad, input int pay_fill, input int drop_tail);
        logic [7:0]  fr [$];
        logic [15:0] c;
        logic [7:0]  b;
        fr.push_back(hdr);
        fr.push_back(sid);
        fr.push_back(cmd);
        fr.push_back(len);
        if (len >= cfcr_pkg::MIN_LEN) begin
            for (int k = 0; k < int'(len) - 2; k++) begin
                b = (pay_fill < 0) ? 8'($urandom) : 8'(pay_fill);
                fr.push_back(b);
            end
            c = cfcr_pkg::CRC_INIT;
            foreach (fr[k]) c = crc16_modbus_byte(c, fr[k]);
            if (crc_bad) c = c ^ 16'($urandom_range(1, 65535));
            fr.push_back(c[7:0]);
            fr.push_back(c[15:8]);
        end
        for (int k = 0; k < drop_tail && fr.size() > 1; k++) void'(fr.pop_back());
        foreach (fr[k]) push_word(fr[k]);
    endtask

    task automatic random_frame(input bit cut);
        logic [7:0] sid;
        logic [7:0] cmd;
        logic [7:0] len;
        sid = ($urandom_range(0, 3) != 0) ? reg_shadow[cfcr_pkg::CFG_STATION] : 8'($urandom);
        cmd = ($urandom_range(0, 9) < 6)
            ? reg_shadow[cfcr_pkg::CFG_CMD0 + $urandom_range(0, 5)] : 8'($urandom);
        len = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(200, 255))
                                           : 8'($urandom_range(2, 10));
        queue_frame(reg_shadow[cfcr_pkg::CFG_HEADER], sid, cmd, len,
                    $urandom_range(0, 6) == 0, -1, cut ? $urandom_range(1, 4) : 0);
    endtask

    task automatic fill_random(input int budget);
        int start;
        int pick;
        logic [7:0] b;
        start = words_queued;
        while (words_queued - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                random_frame(1'b0);
            end else if (pick < 80) begin
                queue_frame(reg_shadow[cfcr_pkg::CFG_HEADER], reg_shadow[cfcr_pkg::CFG_STATION],
                            8'($urandom), 8'($urandom_range(0, 1)), 1'b0, -1, 0);
            end else if (pick < 92) begin
                // line noise between frames, never the header value
                repeat ($urandom_range(1, 3)) begin
                    do b = 8'($urandom); while (b == reg_shadow[cfcr_pkg::CFG_HEADER]);
                    push_word(b);
                end
            end else begin
                random_frame(1'b1);
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (rx_pending.size() != 0 || i_rx_valid || reply_words_due.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic apply_settings();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= cfcr_pkg::CFG_IDX_W'(k);
            i_cfg_data <= next_regs[k];
            reg_shadow[k] = next_regs[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_settings();
        for (int k = 0; k < 8; k++) next_regs[k] = 8'($urandom);
        apply_settings();
    endtask

    initial begin
        reg_shadow[cfcr_pkg::CFG_HEADER]  = cfcr_pkg::RESET_HEADER;
        reg_shadow[cfcr_pkg::CFG_STATION] = cfcr_pkg::RESET_STATION;
        for (int k = 0; k < cfcr_pkg::NUM_CMD; k++)
            reg_shadow[cfcr_pkg::CFG_CMD0 + k] = 8'(cfcr_pkg::CMD_RESET_BASE + k);
        restart_hunt();
        frame_len = 8'h00;
        frame_cmd = 8'h00;
        rx_crc_lo = 8'h00;
        for_us    = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: directed frames first
        push_word(8'h00);                                               // wrong header
        queue_frame(8'hFF, 8'h00, 8'h01, 8'd2, 1'b0, -1, 0);            // known command
        queue_frame(8'hFF, 8'h00, 8'h01, 8'd1, 1'b0, -1, 0);            // short length
        queue_frame(8'hFF, 8'h05, 8'h01, 8'd3, 1'b0, 8'hFF, 0);         // other station, header in body
        queue_frame(8'hFF, 8'h00, 8'hFF, 8'd2, 1'b0, -1, 0);            // unknown command
        queue_frame(8'hFF, 8'h00, 8'h02, 8'd2, 1'b1, -1, 0);            // bad CRC
        fill_random(25);
        wait_drained();

        // extremes, duplicate codes; receiver holds off long while sender runs flat out
        next_regs[cfcr_pkg::CFG_HEADER]  = 8'h00;
        next_regs[cfcr_pkg::CFG_STATION] = 8'hFF;
        for (int k = 0; k < cfcr_pkg::NUM_CMD; k++) next_regs[cfcr_pkg::CFG_CMD0 + k] = 8'hFF;
        apply_settings();
        send_gaps_on <= 1'b0;
        repeat (6) queue_frame(8'h00, 8'hFF, 8'hFF, 8'($urandom_range(2, 4)), 1'b0, -1, 0);
        fill_random(25);
        hold_req <= hold_req + 1;
        wait_drained();

        // other extremes, no idling on either side, longest frame
        next_regs[cfcr_pkg::CFG_HEADER]  = 8'hFF;
        next_regs[cfcr_pkg::CFG_STATION] = 8'h00;
        for (int k = 0; k < cfcr_pkg::NUM_CMD; k++)
            next_regs[cfcr_pkg::CFG_CMD0 + k] = (k % 2) ? 8'hFF : 8'h00;
        apply_settings();
        recv_gaps_on <= 1'b0;
        queue_frame(8'hFF, 8'h00, 8'h00, 8'd255, 1'b0, -1, 0);
        fill_random(25);
        wait_drained();

        random_settings();
        send_gaps_on <= 1'b1;
        recv_gaps_on <= 1'b1;
        fill_random(30);
        wait_drained();

        random_settings();
        recv_gaps_on <= 1'b0;
        fill_random(30);
        wait_drained();

        $display("covered %0d rx words and %0d reply words (%0d replies) over %0d settings,",
                 rx_taken, tx_checked, replies_seen, settings_used);
        $display("with long tx hold-off, rx backpressure and bad/short/foreign/cut frames");
        if (err_count == 0) begin
            $display("tb_crc16_frame_checker_responder: done, clean");
        end else begin
            $display("tb_crc16_frame_checker_responder: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d reply words still expected", reply_words_due.size());
        $display("tb_crc16_frame_checker_responder: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/cfcr_pkg.sv
hw/rtl/cfcr_front.sv
hw/rtl/cfcr_fifo.sv
hw/rtl/cfcr_back.sv
hw/rtl/crc16_frame_checker_responder.sv
dv/tb_crc16_frame_checker_responder.sv
